>>> hdl/amseq_pkg.sv
// ----------------------------------------------------------------------------
// amseq_pkg
// Shared types and constants for the appliance mode sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package amseq_pkg;

   typedef enum logic [2:0] {
      MODE_OFF   = 3'd0,
      MODE_IDLE  = 3'd1,
      MODE_BREW  = 3'd2,
      MODE_PUMP  = 3'd3,
      MODE_STEAM = 3'd4,
      MODE_FLUSH = 3'd5,
      MODE_RINSE = 3'd6,
      MODE_PANIC = 3'd7
   } mode_type;

   typedef enum logic [3:0] {
      OP_POWER_ON        = 4'd0,
      OP_POWER_OFF       = 4'd1,
      OP_PANIC           = 4'd2,
      OP_BREW_START      = 4'd3,
      OP_BREW_STOP       = 4'd4,
      OP_PUMP_START      = 4'd5,
      OP_PUMP_STOP       = 4'd6,
      OP_STEAM_START     = 4'd7,
      OP_STEAM_STOP      = 4'd8,
      OP_BACKFLUSH_START = 4'd9,
      OP_BACKFLUSH_STOP  = 4'd10,
      OP_RINSE_START     = 4'd11,
      OP_RINSE_STOP      = 4'd12,
      OP_TICK            = 4'd13
   } op_type;

   typedef enum logic [3:0] {
      NOTICE_NONE           = 4'd0,
      NOTICE_BREW_START     = 4'd1,
      NOTICE_BREW_STOP      = 4'd2,
      NOTICE_PUMP_START     = 4'd3,
      NOTICE_PUMP_STOP      = 4'd4,
      NOTICE_STEAM_START    = 4'd5,
      NOTICE_STEAM_STOP     = 4'd6,
      NOTICE_FLUSH_START    = 4'd7,
      NOTICE_FLUSH_STOP     = 4'd8,
      NOTICE_RINSE_START    = 4'd9,
      NOTICE_RINSE_STOP     = 4'd10
   } notice_type;

   // register indexes on the configuration port (byte address = 4 * index)
   localparam logic [2:0] REG_IDLE_SETPOINT  = 3'd0;
   localparam logic [2:0] REG_STEAM_SETPOINT = 3'd1;
   localparam logic [2:0] REG_STEAM_TIMEOUT  = 3'd2;
   localparam logic [2:0] REG_PUMP_LOW       = 3'd3;
   localparam logic [2:0] REG_PUMP_HIGH      = 3'd4;

   localparam int unsigned CSR_ADDR_W = 5;

   localparam logic [11:0] IDLE_SETPOINT_RESET  = 12'd0;
   localparam logic [11:0] STEAM_SETPOINT_RESET = 12'd0;
   localparam logic [19:0] STEAM_TIMEOUT_RESET  = 20'hFFFFF;
   localparam logic [7:0]  PUMP_LOW_RESET       = 8'd0;
   localparam logic [7:0]  PUMP_HIGH_RESET      = 8'd255;

   typedef struct packed {
      logic [11:0] idle_setpoint;
      logic [11:0] steam_setpoint;
      logic [19:0] steam_timeout_ticks;
      logic [7:0]  pump_low_power;
      logic [7:0]  pump_high_power;
   } cfg_type;

   typedef struct packed {
      mode_type    mode;
      logic [11:0] heater_setpoint;
      logic        valve_open;
      logic [7:0]  pump_power;
      notice_type  notice;
      logic [7:0]  panic_cause;
   } result_type;

endpackage

`default_nettype wire

>>> hdl/amseq_csr.sv
// ----------------------------------------------------------------------------
// amseq_csr
// Configuration register file behind a simple APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module amseq_csr
   import amseq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output      logic [31:0]           prdata,
   output      logic                  pready,
   output      cfg_type               cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic        wr_en;
   logic [2:0]  reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel & penable & pwrite;
   assign reg_index = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_IDLE_SETPOINT:  cfg_in.idle_setpoint       = pwdata[11:0];
            REG_STEAM_SETPOINT: cfg_in.steam_setpoint      = pwdata[11:0];
            REG_STEAM_TIMEOUT:  cfg_in.steam_timeout_ticks = pwdata[19:0];
            REG_PUMP_LOW:       cfg_in.pump_low_power      = pwdata[7:0];
            REG_PUMP_HIGH:      cfg_in.pump_high_power     = pwdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_setpoint       <= IDLE_SETPOINT_RESET;
         cfg_ff.steam_setpoint      <= STEAM_SETPOINT_RESET;
         cfg_ff.steam_timeout_ticks <= STEAM_TIMEOUT_RESET;
         cfg_ff.pump_low_power      <= PUMP_LOW_RESET;
         cfg_ff.pump_high_power     <= PUMP_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_IDLE_SETPOINT:  prdata = {20'd0, cfg_ff.idle_setpoint};
         REG_STEAM_SETPOINT: prdata = {20'd0, cfg_ff.steam_setpoint};
         REG_STEAM_TIMEOUT:  prdata = {12'd0, cfg_ff.steam_timeout_ticks};
         REG_PUMP_LOW:       prdata = {24'd0, cfg_ff.pump_low_power};
         REG_PUMP_HIGH:      prdata = {24'd0, cfg_ff.pump_high_power};
         default:            prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> hdl/amseq_fsm.sv
// ----------------------------------------------------------------------------
// amseq_fsm
// Mode state machine: holds mode, outputs and steam timer, and works out the
// state after one event or tick.
// ----------------------------------------------------------------------------
`default_nettype none

module amseq_fsm
   import amseq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [3:0] operation,
   input  wire logic [7:0] fault_code,
   input  wire cfg_type    cfg,
   output      result_type result_in
);

   mode_type    mode_ff,     mode_in;
   logic [11:0] setpoint_ff, setpoint_in;
   logic        valve_ff,    valve_in;
   logic [7:0]  pump_ff,     pump_in;
   logic [19:0] ticks_ff,    ticks_in;
   logic [7:0]  cause_ff,    cause_in;

   logic        do_move;
   mode_type    target;
   notice_type  leave_notice;
   notice_type  enter_notice;

   // work mode of a start/stop event
   function automatic mode_type work_mode(input op_type op);
      mode_type m;
      begin
         unique case (op)
            OP_BREW_START, OP_BREW_STOP:           m = MODE_BREW;
            OP_PUMP_START, OP_PUMP_STOP:           m = MODE_PUMP;
            OP_STEAM_START, OP_STEAM_STOP:         m = MODE_STEAM;
            OP_BACKFLUSH_START, OP_BACKFLUSH_STOP: m = MODE_FLUSH;
            OP_RINSE_START, OP_RINSE_STOP:         m = MODE_RINSE;
            default:                               m = MODE_IDLE;
         endcase
         return m;
      end
   endfunction

   always_comb begin
      do_move      = 1'b0;
      target       = mode_ff;
      cause_in     = cause_ff;
      ticks_in     = ticks_ff;
      setpoint_in  = setpoint_ff;
      valve_in     = valve_ff;
      pump_in      = pump_ff;
      leave_notice = NOTICE_NONE;
      enter_notice = NOTICE_NONE;

      unique case (op_type'(operation))
         OP_PANIC: begin
            cause_in = fault_code;
            do_move  = 1'b1;
            target   = MODE_PANIC;
         end
         OP_POWER_OFF: begin
            do_move = (mode_ff != MODE_PANIC);
            target  = MODE_OFF;
         end
         OP_POWER_ON: begin
            do_move = (mode_ff == MODE_OFF) || (mode_ff == MODE_IDLE);
            target  = MODE_IDLE;
         end
         OP_TICK: begin
            if (mode_ff == MODE_STEAM) begin
               ticks_in = ticks_ff + 20'd1;
               do_move  = (ticks_in >= cfg.steam_timeout_ticks);
               target   = MODE_IDLE;
            end
         end
         OP_BREW_START, OP_PUMP_START, OP_STEAM_START, OP_BACKFLUSH_START,
         OP_RINSE_START: begin
            do_move = (mode_ff == MODE_IDLE);
            target  = work_mode(op_type'(operation));
         end
         OP_BREW_STOP, OP_PUMP_STOP, OP_STEAM_STOP, OP_BACKFLUSH_STOP,
         OP_RINSE_STOP: begin
            do_move = (mode_ff == work_mode(op_type'(operation)));
            target  = MODE_IDLE;
         end
         default: begin
            do_move = 1'b0;
         end
      endcase

      if (do_move) begin
         // leave the current mode
         unique case (mode_ff)
            MODE_BREW: begin
               valve_in     = 1'b0;
               pump_in      = cfg.pump_low_power;
               leave_notice = NOTICE_BREW_STOP;
            end
            MODE_PUMP: begin
               pump_in      = cfg.pump_low_power;
               leave_notice = NOTICE_PUMP_STOP;
            end
            MODE_STEAM: leave_notice = NOTICE_STEAM_STOP;
            MODE_FLUSH: leave_notice = NOTICE_FLUSH_STOP;
            MODE_RINSE: leave_notice = NOTICE_RINSE_STOP;
            default:    leave_notice = NOTICE_NONE;
         endcase
         // enter the target mode
         unique case (target)
            MODE_IDLE: begin
               valve_in    = 1'b0;
               setpoint_in = cfg.idle_setpoint;
            end
            MODE_BREW: begin
               valve_in     = 1'b1;
               enter_notice = NOTICE_BREW_START;
            end
            MODE_PUMP: begin
               pump_in      = cfg.pump_high_power;
               enter_notice = NOTICE_PUMP_START;
            end
            MODE_STEAM: begin
               setpoint_in  = cfg.steam_setpoint;
               ticks_in     = 20'd0;
               enter_notice = NOTICE_STEAM_START;
            end
            MODE_FLUSH: enter_notice = NOTICE_FLUSH_START;
            MODE_RINSE: enter_notice = NOTICE_RINSE_START;
            default: begin
               setpoint_in = 12'd0;
               valve_in    = 1'b0;
            end
         endcase
      end

      mode_in = do_move ? target : mode_ff;

      result_in.mode            = mode_in;
      result_in.heater_setpoint = setpoint_in;
      result_in.valve_open      = valve_in;
      result_in.pump_power      = pump_in;
      result_in.notice          = notice_type'(leave_notice | enter_notice);
      result_in.panic_cause     = cause_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_OFF;
         setpoint_ff <= 12'd0;
         valve_ff    <= 1'b0;
         pump_ff     <= PUMP_LOW_RESET;
         ticks_ff    <= 20'd0;
         cause_ff    <= 8'd0;
      end else if (step) begin
         mode_ff     <= mode_in;
         setpoint_ff <= setpoint_in;
         valve_ff    <= valve_in;
         pump_ff     <= pump_in;
         ticks_ff    <= ticks_in;
         cause_ff    <= cause_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/appliance_mode_sequencer_core.sv
// ----------------------------------------------------------------------------
// appliance_mode_sequencer_core
// Espresso controller mode sequencer: events and ticks in, mode and actuator
// settings out, one result word per input word.
// ----------------------------------------------------------------------------
// Takes one event or tick word per clock unless rsp_ready holds it back, and
// returns one result word for each, in order. A word waits in the input
// register and the mode state is updated as it moves into the result register,
// which presents the result until rsp_ready takes it; throughput is one word
// per cycle while rsp_ready keeps up, set by the combinational state update
// between the two registers. req_ready follows rsp_ready combinationally when
// both registers are full. Configuration registers sit at byte addresses 0, 4,
// 8, 12 and 16 and take effect when a mode is entered or left (the steam
// timeout on each steam tick); write them only while no word is in flight.
`default_nettype none

module appliance_mode_sequencer_core
   import amseq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // event channel
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [3:0]            req_operation,
   input  wire logic [7:0]            req_fault_code,
   // result channel
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [2:0]            rsp_mode,
   output      logic [11:0]           rsp_heater_setpoint,
   output      logic                  rsp_valve_open,
   output      logic [7:0]            rsp_pump_power,
   output      logic [3:0]            rsp_notice,
   output      logic [7:0]            rsp_panic_cause,
   // configuration port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output      logic [31:0]           prdata,
   output      logic                  pready
);

   cfg_type     cfg;
   result_type  result_in;
   result_type  rsp_ff;
   logic        rsp_valid_ff;
   logic        req_valid_ff;
   logic [3:0]  op_ff;
   logic [7:0]  fault_ff;
   logic        step;
   logic        accept;

   amseq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // advance the held word when the result register is free or draining
   assign step      = req_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~req_valid_ff | step;
   assign accept    = req_valid & req_ready;

   amseq_fsm u_fsm (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .operation  (op_ff),
      .fault_code (fault_ff),
      .cfg        (cfg),
      .result_in  (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_operation;
         fault_ff <= req_fault_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mode            = rsp_ff.mode;
   assign rsp_heater_setpoint = rsp_ff.heater_setpoint;
   assign rsp_valve_open      = rsp_ff.valve_open;
   assign rsp_pump_power      = rsp_ff.pump_power;
   assign rsp_notice          = rsp_ff.notice;
   assign rsp_panic_cause     = rsp_ff.panic_cause;

   a_step_gives_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("result register not loaded after a step");

   a_valve_only_brewing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.valve_open == (rsp_ff.mode == MODE_BREW)))
      else $error("brew valve state disagrees with mode");

   a_cold_when_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.mode == MODE_OFF || rsp_ff.mode == MODE_PANIC))
      |-> (rsp_ff.heater_setpoint == 12'd0))
      else $error("heater setpoint not zero in off or panic");

endmodule

`default_nettype wire
